// ----- hw/rtl/imh_pkg.sv -----
// Package for the indexed min-heap core: field widths, operation and status
// codes, and the sequencer state type. No dependencies.
package imh_pkg;

  localparam int ITEM_W    = 10;
  localparam int NUM_ITEMS = 1024;
  localparam int KEY_W     = 32;
  localparam logic [KEY_W-1:0] KEY_INF = '1;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_POP = 2'd1,
    OP_UPD = 2'd2,
    OP_ALT = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_DONE        = 3'd0,
    ST_POP_EMPTY   = 3'd1,
    ST_ADD_FULL    = 3'd2,
    ST_ADD_PRESENT = 3'd3,
    ST_UPD_ABSENT  = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_POP_TOP,
    S_POP_TK,
    S_POP_LAST,
    S_POP_LK,
    S_UP_RD,
    S_UP_PI,
    S_UP_PK,
    S_DN_RD,
    S_DN_AI,
    S_DN_AK,
    S_DN_BK,
    S_DN_CMP,
    S_FIN
  } state_e;

endpackage

// ----- hw/rtl/imh_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module imh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hw/rtl/imh_key_cmp.sv -----
// Shared key rank comparator: all-ones ranks above every finite signed key.
// Depends on imh_pkg.
module imh_key_cmp
  import imh_pkg::*;
(
  input  logic [KEY_W-1:0] a_i,
  input  logic [KEY_W-1:0] b_i,
  output logic             lt_o
);

  // True when a ranks strictly below b.
  assign lt_o = (a_i != KEY_INF) &&
                ((b_i == KEY_INF) || ($signed(a_i) < $signed(b_i)));

endmodule

// ----- hw/rtl/indexed_min_heap_core.sv -----
// Indexed binary min-heap with add, pop and key update.
// An add looks up the item and moves it up level by level; an update looks
// it up, then moves it up and down; a pop reads the top and last items and keys,
// then moves the last item down. One transaction at a time, and a waiting result
// holds the sequencer in its final state. Paced by the single read ports and
// the shared comparator. Reset: async active low; clearing marks every item absent.
module indexed_min_heap_core
  import imh_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        op_i,
  input  logic [ITEM_W-1:0] item_i,
  input  logic [KEY_W-1:0]  key_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ITEM_W-1:0] out_item_o,
  output logic [KEY_W-1:0]  out_key_o,
  output logic [2:0]        status_o,
  output logic              was_present_o,
  output logic [10:0]       count_o
);

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(NUM_ITEMS);
  localparam int XW = SW + 2;

  state_e state_q, state_d;

  logic [1:0]        op_q;
  logic [ITEM_W-1:0] item_q, cur_item_q, oth_item_q, b_item_q, res_item_q;
  logic [KEY_W-1:0]  key_q, cur_key_q, oth_key_q, res_key_q;
  logic [SW-1:0]     pos_q, oth_pos_q;
  logic [CW-1:0]     cnt_q;
  logic              present_q, out_valid_q, has_b_q;
  logic [2:0]        res_status_q;
  logic [IW-1:0]     clr_q;

  logic [ITEM_W-1:0] out_item_q;
  logic [KEY_W-1:0]  out_key_q;
  logic [2:0]        out_status_q;
  logic              out_present_q;
  logic [10:0]       out_count_q;

  // RAM ports.
  logic              heap_we, slot_we, key_we;
  logic [SW-1:0]     heap_waddr, heap_raddr;
  logic [ITEM_W-1:0] heap_wdata, heap_rd;
  logic [IW-1:0]     slot_waddr, slot_raddr, key_waddr, key_raddr;
  logic [SW:0]       slot_wdata, slot_rd;
  logic [KEY_W-1:0]  key_wdata, key_rd;

  logic [KEY_W-1:0]  cmp_a, cmp_b;
  logic              cmp_lt;

  logic [XW-1:0]     c1_w, c2_w, cnt_w;
  logic [SW-1:0]     parent;
  logic              in_acc, out_acc;

  imh_ram #(.WIDTH(ITEM_W), .DEPTH(CAPACITY)) u_heap (
    .clk_i, .we_i(heap_we), .waddr_i(heap_waddr), .wdata_i(heap_wdata),
    .raddr_i(heap_raddr), .rdata_o(heap_rd)
  );

  imh_ram #(.WIDTH(SW + 1), .DEPTH(NUM_ITEMS)) u_slot (
    .clk_i, .we_i(slot_we), .waddr_i(slot_waddr), .wdata_i(slot_wdata),
    .raddr_i(slot_raddr), .rdata_o(slot_rd)
  );

  imh_ram #(.WIDTH(KEY_W), .DEPTH(NUM_ITEMS)) u_key (
    .clk_i, .we_i(key_we), .waddr_i(key_waddr), .wdata_i(key_wdata),
    .raddr_i(key_raddr), .rdata_o(key_rd)
  );

  imh_key_cmp u_cmp (.a_i(cmp_a), .b_i(cmp_b), .lt_o(cmp_lt));

  // Tree index arithmetic.
  assign c1_w   = {1'b0, pos_q, 1'b1};
  assign c2_w   = c1_w + XW'(1);
  assign cnt_w  = XW'(cnt_q);
  assign parent = (pos_q - SW'(1)) >> 1;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_acc    = out_valid_q && out_ready_i;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == IW'(NUM_ITEMS - 1)) state_d = S_IDLE;
      S_IDLE: if (in_acc) state_d = S_LOOK;
      S_LOOK: begin
        if (op_q == OP_ADD) begin
          if (slot_rd[SW] || cnt_q == CW'(CAPACITY)) state_d = S_FIN;
          else state_d = S_UP_RD;
        end else if (op_q == OP_UPD) begin
          state_d = slot_rd[SW] ? S_UP_RD : S_FIN;
        end else begin
          state_d = (cnt_q == '0) ? S_FIN : S_POP_TOP;
        end
      end
      S_POP_TOP:  state_d = S_POP_TK;
      S_POP_TK:   state_d = (cnt_q == CW'(1)) ? S_FIN : S_POP_LAST;
      S_POP_LAST: state_d = S_POP_LK;
      S_POP_LK:   state_d = S_DN_RD;
      S_UP_RD: begin
        if (pos_q != '0) state_d = S_UP_PI;
        else state_d = (op_q == OP_ADD) ? S_FIN : S_DN_RD;
      end
      S_UP_PI: state_d = S_UP_PK;
      S_UP_PK: begin
        if (cmp_lt) state_d = S_UP_RD;
        else state_d = (op_q == OP_ADD) ? S_FIN : S_DN_RD;
      end
      S_DN_RD:  state_d = (c1_w < cnt_w) ? S_DN_AI : S_FIN;
      S_DN_AI:  state_d = S_DN_AK;
      S_DN_AK:  state_d = has_b_q ? S_DN_BK : S_DN_CMP;
      S_DN_BK:  state_d = S_DN_CMP;
      S_DN_CMP: state_d = cmp_lt ? S_DN_RD : S_FIN;
      S_FIN: if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  // RAM control and comparator operand selection.
  always_comb begin
    heap_we    = 1'b0;
    heap_waddr = pos_q;
    heap_wdata = oth_item_q;
    heap_raddr = '0;
    slot_we    = 1'b0;
    slot_waddr = oth_item_q;
    slot_wdata = {1'b1, pos_q};
    slot_raddr = item_i;
    key_we     = 1'b0;
    key_waddr  = item_q;
    key_wdata  = key_q;
    key_raddr  = item_i;
    cmp_a      = cur_key_q;
    cmp_b      = key_rd;
    case (state_q)
      S_CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = clr_q;
        slot_wdata = '0;
      end
      S_LOOK: begin
        if ((op_q == OP_ADD && !slot_rd[SW] && cnt_q != CW'(CAPACITY)) ||
            (op_q == OP_UPD && slot_rd[SW])) begin
          key_we = 1'b1;
        end
        heap_raddr = '0;
      end
      S_POP_TOP: key_raddr = heap_rd;
      S_POP_TK: begin
        slot_we    = 1'b1;
        slot_waddr = res_item_q;
        slot_wdata = '0;
        heap_raddr = SW'(cnt_q - CW'(1));
      end
      S_POP_LAST: key_raddr = heap_rd;
      S_UP_RD:    heap_raddr = parent;
      S_UP_PI:    key_raddr = heap_rd;
      S_UP_PK: begin
        cmp_a = cur_key_q;
        cmp_b = key_rd;
        if (cmp_lt) begin
          heap_we = 1'b1;
          slot_we = 1'b1;
        end
      end
      S_DN_RD: heap_raddr = c1_w[SW-1:0];
      S_DN_AI: begin
        key_raddr  = heap_rd;
        heap_raddr = c2_w[SW-1:0];
      end
      S_DN_AK: key_raddr = heap_rd;
      S_DN_BK: begin
        cmp_a = key_rd;
        cmp_b = oth_key_q;
      end
      S_DN_CMP: begin
        cmp_a = oth_key_q;
        cmp_b = cur_key_q;
        if (cmp_lt) begin
          heap_we = 1'b1;
          slot_we = 1'b1;
        end
      end
      S_FIN: begin
        if (res_status_q == ST_DONE && !(op_q != OP_ADD && op_q != OP_UPD &&
            cnt_q == '0)) begin
          heap_we    = 1'b1;
          heap_wdata = cur_item_q;
          slot_we    = 1'b1;
          slot_waddr = cur_item_q;
        end
      end
      default: ;
    endcase
  end

  // Sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + IW'(1);
      if (state_q == S_LOOK && op_q == OP_ADD && !slot_rd[SW] &&
          cnt_q != CW'(CAPACITY)) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (state_q == S_POP_TK) cnt_q <= cnt_q - CW'(1);
      if (state_q == S_FIN && state_d == S_IDLE) out_valid_q <= 1'b1;
      else if (out_acc) out_valid_q <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_q   <= op_i;
          item_q <= item_i;
          key_q  <= key_i;
        end
      end
      S_LOOK: begin
        present_q    <= slot_rd[SW];
        res_item_q   <= item_q;
        res_key_q    <= key_q;
        res_status_q <= ST_DONE;
        cur_item_q   <= item_q;
        cur_key_q    <= key_q;
        if (op_q == OP_ADD) begin
          pos_q <= cnt_q[SW-1:0];
          if (slot_rd[SW]) begin
            res_status_q <= ST_ADD_PRESENT;
            res_key_q    <= key_rd;
          end else if (cnt_q == CW'(CAPACITY)) begin
            res_status_q <= ST_ADD_FULL;
            res_key_q    <= '0;
          end
        end else if (op_q == OP_UPD) begin
          pos_q <= slot_rd[SW-1:0];
          if (!slot_rd[SW]) begin
            res_status_q <= ST_UPD_ABSENT;
            res_key_q    <= '0;
          end
        end else if (cnt_q == '0) begin
          res_status_q <= ST_POP_EMPTY;
          res_item_q   <= '0;
          res_key_q    <= '0;
        end
      end
      S_POP_TOP: res_item_q <= heap_rd;
      S_POP_TK:  res_key_q <= key_rd;
      S_POP_LAST: cur_item_q <= heap_rd;
      S_POP_LK: begin
        cur_key_q <= key_rd;
        pos_q     <= '0;
      end
      S_UP_PI: oth_item_q <= heap_rd;
      S_UP_PK: if (cmp_lt) pos_q <= parent;
      S_DN_AI: begin
        oth_item_q <= heap_rd;
        oth_pos_q  <= c1_w[SW-1:0];
        has_b_q    <= (c2_w < cnt_w);
      end
      S_DN_AK: begin
        oth_key_q <= key_rd;
        b_item_q  <= heap_rd;
      end
      S_DN_BK: begin
        if (cmp_lt) begin
          oth_item_q <= b_item_q;
          oth_key_q  <= key_rd;
          oth_pos_q  <= c2_w[SW-1:0];
        end
      end
      S_DN_CMP: if (cmp_lt) pos_q <= oth_pos_q;
      S_FIN: begin
        if (state_d == S_IDLE) begin
          out_item_q    <= res_item_q;
          out_key_q     <= res_key_q;
          out_status_q  <= res_status_q;
          out_present_q <= present_q;
          out_count_q   <= 11'(cnt_q);
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign out_item_o    = out_item_q;
  assign out_key_o     = out_key_q;
  assign status_o      = out_status_q;
  assign was_present_o = out_present_q;
  assign count_o       = out_count_q;

endmodule

// ----- hw/rtl/imh_checker.sv -----
// Port-level checker for the indexed min-heap core, bound to the top level.
// Depends on imh_pkg.
module imh_checker
  import imh_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic [1:0]        op_i,
  input logic [ITEM_W-1:0] item_i,
  input logic [KEY_W-1:0]  key_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [ITEM_W-1:0] out_item_o,
  input logic [KEY_W-1:0]  out_key_o,
  input logic [2:0]        status_o,
  input logic              was_present_o,
  input logic [10:0]       count_o
);

  // A waiting result transaction holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_key_o) &&
    $stable(out_item_o) && $stable(count_o))
    else $error("result changed while stalled");

  // A pop on an empty heap reports a zero item and key and leaves it empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_POP_EMPTY |->
    out_item_o == '0 && out_key_o == '0 && count_o == '0)
    else $error("bad empty pop result");

  // A full add reports the capacity as count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_ADD_FULL |-> count_o == 11'(CAPACITY) &&
    !was_present_o)
    else $error("bad full add result");

  // Presence flags agree with the error codes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_UPD_ABSENT |-> !was_present_o &&
    out_key_o == '0)
    else $error("bad absent update result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_ADD_PRESENT |-> was_present_o)
    else $error("bad duplicate add result");

endmodule

bind indexed_min_heap_core imh_checker #(.CAPACITY(CAPACITY)) u_imh_checker (.*);

// ----- tb/sv/tb_indexed_min_heap_core.sv -----
// Self-checking testbench for indexed_min_heap_core: a directed opening, a deep
// fill and drain of the heap, and a random mix. Depends on imh_pkg and the core.
module tb_indexed_min_heap_core;
  import imh_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP        = 1024;
  localparam int IDLE_LIMIT = 20000;
  localparam int TAIL_WAIT  = 200;

  typedef struct {
    op_e               op;
    logic [ITEM_W-1:0] item;
    logic [KEY_W-1:0]  key;
    bit                drain;
  } heap_req_t;

  typedef struct {
    logic [ITEM_W-1:0] item;
    logic [KEY_W-1:0]  key;
    status_e           status;
    logic              was_present;
    logic [10:0]       count;
  } heap_resp_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [1:0]        op_i = OP_ADD;
  logic [ITEM_W-1:0] item_i = '0;
  logic [KEY_W-1:0]  key_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [ITEM_W-1:0] out_item_o;
  logic [KEY_W-1:0]  out_key_o;
  logic [2:0]        status_o;
  logic              was_present_o;
  logic [10:0]       count_o;

  indexed_min_heap_core #(.CAPACITY(CAP)) dut (.*);

  // Shadow heap state.
  logic [ITEM_W-1:0] shadow_heap [CAP];
  int                shadow_slot [NUM_ITEMS];
  bit                shadow_present [NUM_ITEMS];
  logic [KEY_W-1:0]  shadow_key [NUM_ITEMS];
  int                shadow_count = 0;

  heap_req_t  pending_q [$];
  heap_resp_t expected_q [$];
  int         n_errors = 0;
  int         n_results = 0;
  int         n_status [5];
  int         max_depth = 0;
  bit         stim_done = 1'b0;

  // Infinite keys rank above all finite keys; finite keys compare signed.
  function automatic logic [32:0] key_rank(logic [KEY_W-1:0] k);
    if (k == KEY_INF) return 33'h1_0000_0000;
    return {1'b0, k ^ 32'h8000_0000};
  endfunction

  function automatic logic [32:0] slot_rank(int s);
    return key_rank(shadow_key[shadow_heap[s]]);
  endfunction

  function automatic void swap_slots(int a, int b);
    logic [ITEM_W-1:0] ia, ib;
    ia = shadow_heap[a];
    ib = shadow_heap[b];
    shadow_heap[a] = ib;
    shadow_heap[b] = ia;
    shadow_slot[ia] = b;
    shadow_slot[ib] = a;
  endfunction

  function automatic int bubble_up(int pos);
    int parent;
    while (pos > 0) begin
      parent = (pos - 1) / 2;
      if (slot_rank(parent) > slot_rank(pos)) begin
        swap_slots(parent, pos);
        pos = parent;
      end else begin
        break;
      end
    end
    return pos;
  endfunction

  function automatic void bubble_down(int pos);
    int child;
    while (2 * pos + 1 < shadow_count) begin
      child = 2 * pos + 1;
      if (child + 1 < shadow_count && slot_rank(child + 1) < slot_rank(child)) child++;
      if (slot_rank(child) < slot_rank(pos)) begin
        swap_slots(pos, child);
        pos = child;
      end else begin
        break;
      end
    end
  endfunction

  // Applies one operation to the shadow heap and returns the expected response.
  function automatic heap_resp_t apply_heap_op(op_e op, logic [ITEM_W-1:0] item,
                                               logic [KEY_W-1:0] key);
    heap_resp_t r;
    logic [ITEM_W-1:0] top, last;
    int pos;
    r.item = item;
    r.key = '0;
    r.status = ST_DONE;
    r.was_present = shadow_present[item];
    case (op)
      OP_ADD: begin
        if (shadow_present[item]) begin
          r.status = ST_ADD_PRESENT;
          r.key = shadow_key[item];
        end else if (shadow_count >= CAP) begin
          r.status = ST_ADD_FULL;
        end else begin
          shadow_key[item] = key;
          shadow_heap[shadow_count] = item;
          shadow_slot[item] = shadow_count;
          shadow_present[item] = 1'b1;
          shadow_count++;
          void'(bubble_up(shadow_count - 1));
          r.key = key;
        end
      end
      OP_UPD: begin
        if (!shadow_present[item]) begin
          r.status = ST_UPD_ABSENT;
        end else begin
          shadow_key[item] = key;
          pos = bubble_up(shadow_slot[item]);
          bubble_down(pos);
          r.key = key;
        end
      end
      default: begin
        // Pop, with the spare code treated the same way.
        if (shadow_count == 0) begin
          r.status = ST_POP_EMPTY;
          r.item = '0;
        end else begin
          top = shadow_heap[0];
          r.item = top;
          r.key = shadow_key[top];
          shadow_count--;
          last = shadow_heap[shadow_count];
          shadow_present[top] = 1'b0;
          if (shadow_count > 0) begin
            shadow_heap[0] = last;
            shadow_slot[last] = 0;
            bubble_down(0);
          end
        end
      end
    endcase
    r.count = shadow_count[10:0];
    if (shadow_count > max_depth) max_depth = shadow_count;
    return r;
  endfunction

  // Clock.
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Input driver: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i) begin
    heap_req_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_q.push_back(apply_heap_op(op_e'(op_i), item_i, key_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() > 0 &&
                     !(pending_q[0].drain && expected_q.size() > 0)) begin
          nxt = pending_q.pop_front();
          in_valid_i <= 1'b1;
          op_i <= nxt.op;
          item_i <= nxt.item;
          key_i <= nxt.key;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor with a receiver stall pattern that changes over the run.
  int stall_mode = 0;
  int cyc = 0;
  always @(posedge clk_i) begin
    heap_resp_t e;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      cyc <= cyc + 1;
      if (out_valid_o && out_ready_i) begin
        n_results++;
        if (expected_q.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected transaction item=%0d key=%h status=%0d", $time,
                   out_item_o, out_key_o, status_o);
        end else begin
          e = expected_q.pop_front();
          n_status[e.status]++;
          if (out_item_o !== e.item) begin
            n_errors++;
            $display("%0t: out_item expected %0d actual %0d", $time, e.item, out_item_o);
          end
          if (out_key_o !== e.key) begin
            n_errors++;
            $display("%0t: out_key expected %h actual %h", $time, e.key, out_key_o);
          end
          if (status_o !== e.status) begin
            n_errors++;
            $display("%0t: status expected %0d actual %0d", $time, e.status, status_o);
          end
          if (was_present_o !== e.was_present) begin
            n_errors++;
            $display("%0t: was_present expected %0d actual %0d", $time, e.was_present,
                     was_present_o);
          end
          if (count_o !== e.count) begin
            n_errors++;
            $display("%0t: count expected %0d actual %0d", $time, e.count, count_o);
          end
        end
      end
      if (cyc % 64 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= $urandom_range(0, 1);
        2: out_ready_i <= (cyc % 3 != 0);
        default: out_ready_i <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Watchdog: cycles with no transaction on either channel.
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", IDLE_LIMIT);
      $display("indexed_min_heap_core regression: fail");
      $finish;
    end
  end

  task automatic queue_op(op_e op, int item, logic [KEY_W-1:0] key, bit drain = 0);
    heap_req_t r;
    r.op = op;
    r.item = item[ITEM_W-1:0];
    r.key = key;
    r.drain = drain;
    pending_q.push_back(r);
  endtask

  // Keys lean toward small values so that equal keys are common.
  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0:       return KEY_INF;
      1:       return $urandom;
      2:       return 32'h8000_0000 | $urandom_range(0, 1000);
      3:       return 32'h7fff_ffff - $urandom_range(0, 3);
      default: return $urandom_range(0, 20);
    endcase
  endfunction

  // Stimulus.
  initial begin
    int item;
    int r;
    for (int i = 0; i < NUM_ITEMS; i++) begin
      shadow_present[i] = 1'b0;
      shadow_key[i] = '0;
      shadow_slot[i] = 0;
    end

    // Directed opening: extremes, every operation, pop-empty, update-absent and add-present.
    queue_op(OP_POP, 0, '0);
    queue_op(OP_UPD, 77, 32'd5);
    queue_op(OP_ADD, 0, 32'd0);
    queue_op(OP_ADD, 1023, KEY_INF);
    queue_op(OP_ADD, 512, 32'h7fff_ffff);
    queue_op(OP_ADD, 5, 32'h8000_0000);
    queue_op(OP_ADD, 6, 32'hffff_fffb);
    queue_op(OP_ADD, 0, 32'd9);
    queue_op(OP_ADD, 7, 32'd3);
    queue_op(OP_ADD, 8, 32'd3);
    queue_op(OP_UPD, 1023, 32'd3);
    queue_op(OP_UPD, 0, KEY_INF);
    queue_op(OP_UPD, 5, 32'h5555_aaaa);
    queue_op(OP_ALT, 1023, '0);
    for (int i = 0; i < 7; i++) queue_op(OP_POP, 0, '0);
    queue_op(OP_POP, 341, '0);

    // Deep fill with distinct items, then drain; the first pop waits for all
    // results so the pipeline runs empty.
    for (int i = 0; i < 300; i++) queue_op(OP_ADD, (i * 37 + 11) % NUM_ITEMS, pick_key());
    for (int i = 0; i < 40; i++) queue_op(OP_UPD, (i * 37 + 11) % NUM_ITEMS, pick_key());
    queue_op(OP_POP, 0, '0, 1);
    for (int i = 0; i < 300; i++) queue_op(OP_POP, $urandom_range(0, 1023), '0);

    // Random mix over a small item pool so updates mostly hit present items.
    for (int i = 0; i < 190; i++) begin
      item = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 63);
      r = $urandom_range(0, 19);
      if (i == 95) queue_op(OP_POP, item, '0, 1);
      else if (r < 8) queue_op(OP_ADD, item, pick_key());
      else if (r < 13) queue_op(OP_UPD, item, pick_key());
      else if (r < 19) queue_op(OP_POP, item, $urandom);
      else queue_op(OP_ALT, item, $urandom);
    end
    stim_done = 1'b1;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (pending_q.size() > 0 || in_valid_i || expected_q.size() > 0);
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (expected_q.size() > 0) begin
      n_errors++;
      $display("%0t: %0d expected transactions never arrived", $time, expected_q.size());
    end

    $display("Checked %0d results: %0d done, %0d pop-empty, %0d add-present, %0d upd-absent.",
             n_results, n_status[ST_DONE], n_status[ST_POP_EMPTY], n_status[ST_ADD_PRESENT],
             n_status[ST_UPD_ABSENT]);
    $display("Largest heap reached %0d items; %0d mismatches.", max_depth, n_errors);
    if (n_errors == 0) begin
      $display("indexed_min_heap_core regression: pass");
    end else begin
      $display("indexed_min_heap_core regression: fail");
    end
    $finish;
  end

endmodule
